// ===== src/breakpoint_gain_envelope_core_macros.svh =====
// assertion macros for the gain envelope block
`ifndef BREAKPOINT_GAIN_ENVELOPE_CORE_MACROS_SVH
`define BREAKPOINT_GAIN_ENVELOPE_CORE_MACROS_SVH
// assert that a condition implies a consequent in the same cycle
`define BGE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// assert that a condition implies a consequent in the next cycle
`define BGE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/bge_pkg.sv =====
// shared constants and types for the gain envelope block
package bge_pkg;
  localparam int MaxPoints = 16;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int MaxChannels = 8;
  localparam int ChW = 3;
  localparam logic [15:0] UnityGain = 16'd4096;
  localparam logic [9:0] MsPerSecond = 10'd1000;

  // item function codes
  localparam logic FuncAdd = 1'b0;
  localparam logic FuncSample = 1'b1;

  // configuration register indexes
  localparam logic RegSampleRate = 1'b0;
  localparam logic RegChannelCount = 1'b1;

  typedef struct packed {
    logic [23:0] t;
    logic [15:0] g;
  } bge_point_t;

  // control from the sequencer to the cell row
  typedef struct packed {
    logic             ins;
    logic [23:0]      t;
    logic [15:0]      g;
    logic [CntW-1:0]  count;
  } bge_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SEG  = 5'b00100,
    ST_IDIV = 5'b01000,
    ST_OUT  = 5'b10000
  } bge_state_t;
endpackage

// ===== src/bge_cell.sv =====
// one breakpoint cell of the sorted insertion row
module bge_cell (
  input  logic                 clk,
  input  logic [bge_pkg::IdxW-1:0] pos,
  input  bge_pkg::bge_ctl_t    ctl,
  input  bge_pkg::bge_point_t  left_pt,
  input  logic                 left_gt,
  output bge_pkg::bge_point_t  pt,
  output logic                 gt
);
  logic used;
  // entry holds a valid point greater than the new time
  assign used = ({1'b0, pos} < ctl.count);
  assign gt = used && (pt.t > ctl.t);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left_gt) begin
        pt <= left_pt;
      end else if (gt || ({1'b0, pos} == ctl.count)) begin
        pt <= '{t: ctl.t, g: ctl.g};
      end
    end
  end
endmodule

// ===== src/breakpoint_gain_envelope_core.sv =====
// top level of the piecewise-linear gain envelope block
//   channel | signals                                         | direction
//   in      | in_valid in_ready func point_* sample_in clip_start | input
//   out     | out_valid out_ready sample_out gain_used saturated | output
//   cfg     | cfg_we cfg_index cfg_data                        | input
// an add transaction is stored in the cell row unless the table is full
// a sample transaction runs the serial time divide, the segment scan, the
// interpolation divide when the time falls inside a segment, and a register
// for the product; a result waiting at the output holds the next sample
// in the output state; rst clears frame and channel counters, point count,
// out_valid; loads rate 44100, one channel; table and datapath not cleared
module breakpoint_gain_envelope_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [23:0] point_time_ms,
  input  logic [15:0] point_gain,
  input  logic signed [23:0] sample_in,
  input  logic        clip_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [23:0] sample_out,
  output logic [15:0] gain_used,
  output logic        saturated,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [17:0] cfg_data
);
  `include "breakpoint_gain_envelope_core_macros.svh"
  localparam int N = bge_pkg::MaxPoints;

  bge_pkg::bge_state_t state;
  logic [17:0] sample_rate;
  logic [3:0]  channel_count;
  logic [bge_pkg::CntW-1:0] point_count;
  logic [31:0] frame_index;
  logic [bge_pkg::ChW-1:0] channel_index;
  logic signed [23:0] smp;
  bge_pkg::bge_ctl_t ctl;
  bge_pkg::bge_point_t pts [N];
  logic gts [N];

  // insertion row
  assign ctl.ins = (state == bge_pkg::ST_IDLE) && in_valid && (func == bge_pkg::FuncAdd) &&
                   (point_count < bge_pkg::CntW'(N));
  assign ctl.t = point_time_ms;
  assign ctl.g = point_gain;
  assign ctl.count = point_count;

  for (genvar i = 0; i < N; i++) begin : g_cell
    bge_pkg::bge_point_t lp;
    logic lg;
    if (i == 0) begin : g_first
      assign lp = '0;
      assign lg = 1'b0;
    end else begin : g_rest
      assign lp = pts[i-1];
      assign lg = gts[i-1];
    end
    bge_cell u_cell (
      .clk(clk), .pos(bge_pkg::IdxW'(i)), .ctl(ctl),
      .left_pt(lp), .left_gt(lg), .pt(pts[i]), .gt(gts[i])
    );
  end

  assign in_ready = (state == bge_pkg::ST_IDLE);

  // serial divider shared by time and interpolation
  logic [41:0] quo;
  logic [41:0] rem;
  logic [41:0] dvs;
  logic [5:0]  step;
  logic [42:0] rem_sh;
  logic        neg;
  logic [41:0] quo_next;
  logic [41:0] rem_next;
  assign rem_sh = {rem, quo[41]};

  always_comb begin
    if (rem_sh >= {1'b0, dvs}) begin
      rem_next = 42'(rem_sh - {1'b0, dvs});
      quo_next = {quo[40:0], 1'b1};
    end else begin
      rem_next = rem_sh[41:0];
      quo_next = {quo[40:0], 1'b0};
    end
  end

  logic [bge_pkg::IdxW-1:0] seg;
  logic [15:0] g0, gain;
  logic [bge_pkg::IdxW-1:0] last;
  assign last = bge_pkg::IdxW'(point_count - 1'b1);

  logic [3:0] chans;
  always_comb begin
    chans = channel_count;
    if (chans == 4'd0) chans = 4'd1;
    if (chans > 4'(bge_pkg::MaxChannels)) chans = 4'(bge_pkg::MaxChannels);
  end

  logic signed [40:0] prod;
  logic signed [28:0] q;
  assign q = 29'(prod >>> 12);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bge_pkg::ST_IDLE;
      sample_rate <= 18'd44100;
      channel_count <= 4'd1;
      point_count <= '0;
      frame_index <= '0;
      channel_index <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bge_pkg::RegSampleRate) sample_rate <= cfg_data;
        else channel_count <= cfg_data[3:0];
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        bge_pkg::ST_IDLE: begin
          if (in_valid && in_ready) begin
            if (func == bge_pkg::FuncAdd) begin
              if (ctl.ins) point_count <= point_count + 1'b1;
            end else begin
              smp <= sample_in;
              if (clip_start) begin
                frame_index <= '0;
                channel_index <= '0;
                quo <= '0;
              end else begin
                quo <= 42'(frame_index) * 42'(bge_pkg::MsPerSecond);
              end
              rem <= '0;
              dvs <= (sample_rate == '0) ? 42'd1 : 42'(sample_rate);
              step <= 6'd42;
              neg <= 1'b0;
              state <= bge_pkg::ST_DIV;
            end
          end
        end
        bge_pkg::ST_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          step <= step - 1'b1;
          if (step == 6'd1) begin
            state <= bge_pkg::ST_SEG;
            seg <= '0;
          end
        end
        bge_pkg::ST_SEG: begin
          if (point_count == '0) begin
            gain <= bge_pkg::UnityGain;
            state <= bge_pkg::ST_OUT;
          end else if (quo < 42'(pts[0].t)) begin
            gain <= pts[0].g;
            state <= bge_pkg::ST_OUT;
          end else if (quo >= 42'(pts[last].t)) begin
            gain <= pts[last].g;
            state <= bge_pkg::ST_OUT;
          end else if (quo < 42'(pts[seg + 1'b1].t)) begin
            g0 <= pts[seg].g;
            // numerator magnitude dt*|diff|, divided by span
            begin
              logic [23:0] dt;
              logic [16:0] d;
              dt = 24'(quo[23:0] - pts[seg].t);
              d = (pts[seg+1'b1].g >= pts[seg].g) ?
                  17'(pts[seg+1'b1].g - pts[seg].g) : 17'(pts[seg].g - pts[seg+1'b1].g);
              neg <= pts[seg+1'b1].g < pts[seg].g;
              quo <= 42'(dt) * 42'(d);
              rem <= '0;
              dvs <= 42'(pts[seg+1'b1].t - pts[seg].t);
              step <= 6'd42;
            end
            state <= bge_pkg::ST_IDIV;
          end else begin
            seg <= seg + 1'b1;
          end
        end
        bge_pkg::ST_IDIV: begin
          rem <= rem_next;
          quo <= quo_next;
          step <= step - 1'b1;
          if (step == 6'd1) begin
            gain <= neg ? 16'(g0 - quo_next[15:0]) : 16'(g0 + quo_next[15:0]);
            state <= bge_pkg::ST_OUT;
          end
        end
        bge_pkg::ST_OUT: begin
          if (!out_valid) begin
            prod <= smp * $signed({1'b0, gain});
            out_valid <= 1'b1;
            gain_used <= gain;
            state <= bge_pkg::ST_IDLE;
            if ({1'b0, channel_index} + 4'd1 >= chans) begin
              channel_index <= '0;
              frame_index <= frame_index + 1'b1;
            end else begin
              channel_index <= channel_index + 1'b1;
            end
          end
        end
        default: state <= bge_pkg::ST_IDLE;
      endcase
    end
  end

  // saturation stage works on the registered product
  always_comb begin
    if (q > 29'sd8388607) begin
      sample_out = 24'sh7FFFFF;
      saturated = 1'b1;
    end else if (q < -29'sd8388608) begin
      sample_out = 24'sh800000;
      saturated = 1'b1;
    end else begin
      sample_out = 24'(q);
      saturated = 1'b0;
    end
  end

  `BGE_ASSERT_IMP(a_count_max, 1'b1, point_count <= bge_pkg::CntW'(N))
  `BGE_ASSERT_NEXT(a_add_grows, ctl.ins, point_count == $past(point_count) + 1'b1)
  `BGE_ASSERT_IMP(a_no_in_busy, state != bge_pkg::ST_IDLE, !in_ready)
  `BGE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(gain_used) && $stable(sample_out))
endmodule

// ===== verif/breakpoint_gain_envelope_core_tb.sv =====
// testbench for the gain envelope block: sends add and sample transactions and compares each result with a built-in prediction
`timescale 1ns / 100ps
module breakpoint_gain_envelope_core_tb;
  typedef struct packed {
    logic signed [23:0] sample;
    logic [15:0] gain;
    logic sat;
  } env_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [23:0] point_time_ms = '0;
  logic [15:0] point_gain = '0;
  logic signed [23:0] sample_in = '0;
  logic clip_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] sample_out;
  logic [15:0] gain_used;
  logic saturated;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [17:0] cfg_data = '0;

  logic [23:0] env_times [bge_pkg::MaxPoints];
  logic [15:0] env_gains [bge_pkg::MaxPoints];
  int unsigned env_count;
  logic [31:0] frame_cnt;
  int unsigned chan_cnt;
  logic [17:0] rate_reg;
  logic [3:0] chans_reg;
  env_result_t gain_results_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic holding = 1'b0;
  event hold_ev;

  breakpoint_gain_envelope_core u_top (.*);

  always #5 clk = ~clk;

  function automatic logic [15:0] envelope_gain(longint unsigned t);
    longint g0, diff, dt, span;
    if (env_count == 0) return bge_pkg::UnityGain;
    if (t < env_times[0]) return env_gains[0];
    if (t >= env_times[env_count-1]) return env_gains[env_count-1];
    for (int i = 0; i + 1 < env_count; i++) begin
      if (t >= env_times[i] && t < env_times[i+1]) begin
        g0 = env_gains[i];
        diff = longint'(env_gains[i+1]) - g0;
        dt = longint'(t) - longint'(env_times[i]);
        span = longint'(env_times[i+1]) - longint'(env_times[i]);
        return 16'(g0 + (dt * diff) / span);
      end
    end
    return env_gains[env_count-1];
  endfunction

  task automatic apply_envelope(logic f, logic [23:0] t, logic [15:0] g,
                                logic signed [23:0] s, logic clip);
    int unsigned pos, nch;
    longint unsigned tms, rate;
    longint p, q;
    env_result_t r;
    if (f == bge_pkg::FuncAdd) begin
      if (env_count >= bge_pkg::MaxPoints) return;
      pos = env_count;
      while (pos > 0 && env_times[pos-1] > t) pos--;
      for (int k = env_count; k > pos; k--) begin
        env_times[k] = env_times[k-1];
        env_gains[k] = env_gains[k-1];
      end
      env_times[pos] = t;
      env_gains[pos] = g;
      env_count++;
      return;
    end
    if (clip) begin
      frame_cnt = 0;
      chan_cnt = 0;
    end
    rate = (rate_reg == 0) ? 1 : rate_reg;
    tms = (longint'(frame_cnt) * 1000) / rate;
    r.gain = envelope_gain(tms);
    p = longint'(s) * longint'(r.gain);
    q = (p >= 0) ? p / 4096 : -((-p + 4095) / 4096);
    r.sat = 1'b0;
    if (q > 8388607) begin q = 8388607; r.sat = 1'b1; end
    if (q < -8388608) begin q = -8388608; r.sat = 1'b1; end
    r.sample = 24'(q);
    gain_results_q.push_back(r);
    nch = (chans_reg == 0) ? 1 :
          (chans_reg > bge_pkg::MaxChannels) ? bge_pkg::MaxChannels : chans_reg;
    if (chan_cnt + 1 >= nch) begin
      chan_cnt = 0;
      frame_cnt = frame_cnt + 1;
    end else begin
      chan_cnt++;
    end
  endtask

  task automatic send_item(logic f, logic [23:0] t, logic [15:0] g,
                           logic signed [23:0] s, logic clip);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    point_time_ms <= t;
    point_gain <= g;
    sample_in <= s;
    clip_start <= clip;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_envelope(f, t, g, s, clip);
  endtask

  task automatic drain;
    int n = 0;
    in_valid <= 1'b0;
    while (gain_results_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [17:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bge_pkg::RegSampleRate) rate_reg = val;
    else chans_reg = val[3:0];
  endtask

  task automatic send_sample(logic clip);
    send_item(bge_pkg::FuncSample, 24'($urandom), 16'($urandom), 24'($urandom), clip);
  endtask

  // long receiver hold-off, counted in cycles
  initial begin
    forever begin
      @(hold_ev);
      holding <= 1'b1;
      repeat (400) @(posedge clk);
      holding <= 1'b0;
    end
  end

  // receiver
  always @(posedge clk) begin
    env_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (gain_results_q.size() == 0) begin
        $display("%0t: unexpected result sample=%0d gain=%0d sat=%0b", $time,
                 sample_out, gain_used, saturated);
        errors++;
      end else begin
        e = gain_results_q.pop_front();
        if (sample_out !== e.sample || gain_used !== e.gain || saturated !== e.sat) begin
          $display("%0t: expected sample=%0d gain=%0d sat=%0b, actual sample=%0d gain=%0d sat=%0b",
                   $time, e.sample, e.gain, e.sat, sample_out, gain_used, saturated);
          errors++;
        end
      end
    end
    if (rst) out_ready <= 1'b0;
    else if (holding) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic test_empty_table;
    send_item(bge_pkg::FuncSample, '0, '0, 24'sh7FFFFF, 1'b1);
    send_item(bge_pkg::FuncSample, '0, '0, -24'sh800000, 1'b0);
    send_item(bge_pkg::FuncSample, '0, '0, 24'sd0, 1'b0);
  endtask

  task automatic test_directed;
    write_reg(bge_pkg::RegSampleRate, 18'd8000);
    write_reg(bge_pkg::RegChannelCount, 18'd2);
    send_item(bge_pkg::FuncAdd, 24'd1, 16'hFFFF, '0, 1'b0);
    send_item(bge_pkg::FuncAdd, 24'd0, 16'd0, '0, 1'b0);
    send_item(bge_pkg::FuncAdd, 24'd1, 16'd100, '0, 1'b0);
    send_item(bge_pkg::FuncAdd, 24'd3, 16'd8000, '0, 1'b0);
    send_item(bge_pkg::FuncAdd, 24'hFFFFFF, 16'd4096, '0, 1'b0);
    for (int i = 0; i < 10; i++)
      send_item(bge_pkg::FuncSample, '0, '0, (i % 2) ? 24'sh7FFFFF : -24'sh800000, i == 0);
    for (int i = 0; i < 13; i++)
      send_item(bge_pkg::FuncAdd, 24'($urandom_range(5)), 16'($urandom), '0, 1'b0);
    send_item(bge_pkg::FuncSample, '0, '0, 24'sh123456, 1'b1);
  endtask

  task automatic test_random(int n, int rate, int chans);
    write_reg(bge_pkg::RegSampleRate, 18'(rate));
    write_reg(bge_pkg::RegChannelCount, 18'(chans));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_item(bge_pkg::FuncAdd, 24'($urandom), 16'($urandom), 24'($urandom),
                  1'($urandom));
      else send_sample($urandom_range(39) == 0);
    end
  endtask

  task automatic test_backpressure;
    -> hold_ev;
    for (int i = 0; i < 20; i++) send_sample(1'b0);
  endtask

  initial begin
    rate_reg = 18'd44100;
    chans_reg = 4'd1;
    env_count = 0;
    frame_cnt = 0;
    chan_cnt = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_directed();
    test_random(250, 192000, 1);
    send_idle_pct = 65;
    test_random(250, 0, 0);
    send_idle_pct = 0;
    recv_stall_pct = 65;
    test_random(250, 8000, 8);
    send_idle_pct = 18;
    recv_stall_pct = 18;
    test_random(250, 262143, 15);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(220, 48000, 3);
    test_backpressure();
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/bge_pkg.sv
src/bge_cell.sv
src/breakpoint_gain_envelope_core.sv
verif/breakpoint_gain_envelope_core_tb.sv
